FILE: hdl/dtse_pkg.sv
// Shared types, codes and calendar functions of the date and time set editor.
package dtse_pkg;

  // Reset values of the year bounds and of the edited date and time.
  localparam logic [11:0] YEAR_MIN_RST = 12'd2024;
  localparam logic [11:0] YEAR_MAX_RST = 12'd2099;
  localparam logic [11:0] YEAR_DEF     = 12'd2026;

  // Request operation codes.
  localparam logic [1:0] OP_EVENT   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_DEFAULT = 2'd2;

  // Event origin and kind codes.
  localparam logic [1:0] SRC_BUTTON    = 2'd0;
  localparam logic [1:0] SRC_KEYBOARD  = 2'd1;
  localparam logic [1:0] KIND_SHORT    = 2'd0;
  localparam logic [1:0] KIND_LONG     = 2'd1;
  localparam logic [1:0] KIND_KEYPRESS = 2'd2;

  localparam logic [7:0] BUTTON_A = 8'h00;

  // Key bytes.
  localparam logic [7:0] KEY_ESC     = 8'h1B;
  localparam logic [7:0] KEY_BRACKET = 8'h5B;
  localparam logic [7:0] KEY_CR      = 8'h0D;
  localparam logic [7:0] KEY_UP      = 8'h41;
  localparam logic [7:0] KEY_DOWN    = 8'h42;
  localparam logic [7:0] KEY_RIGHT   = 8'h43;
  localparam logic [7:0] KEY_LEFT    = 8'h44;
  localparam logic [3:0] KEY_LEN_ONE = 4'd1;
  localparam logic [3:0] KEY_LEN_SEQ = 4'd3;

  // Cursor codes.
  localparam logic [2:0] CUR_YEAR   = 3'd0;
  localparam logic [2:0] CUR_MONTH  = 3'd1;
  localparam logic [2:0] CUR_DAY    = 3'd2;
  localparam logic [2:0] CUR_HOUR   = 3'd3;
  localparam logic [2:0] CUR_MINUTE = 3'd4;
  localparam logic [2:0] CUR_SECOND = 3'd5;

  // Register indexes on the configuration port.
  localparam logic REG_YEAR_MIN = 1'b0;
  localparam logic REG_YEAR_MAX = 1'b1;

  // Divisibility by 25 on a 12-bit year: multiply by the inverse of 25
  // modulo 4096; the product is a multiple's quotient only for multiples.
  localparam logic [11:0] INV25     = 12'd3113;
  localparam logic [11:0] DIV25_MAX = 12'd163;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SAVE   = 2'd1,
    ACT_CANCEL = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DEFAULT,
    CMD_STEP_UP,
    CMD_STEP_DN,
    CMD_CUR_NEXT,
    CMD_CUR_PREV
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    action_t action;
  } cmd_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } dt_t;

  function automatic logic is_leap(input logic [11:0] y);
    logic [23:0] prod;
    logic        div4;
    logic        div16;
    logic        div25;
    prod  = y * INV25;
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (prod[11:0] <= DIV25_MAX);
    return (div4 && !div25) || (div16 && div25);
  endfunction

  function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2:                    d = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  // Step by one and wrap within lo..hi; low test first, then high test.
  function automatic logic [11:0] wrap_year(input logic [11:0] v, input logic up,
                                            input logic [11:0] lo, input logic [11:0] hi);
    logic signed [13:0] r;
    r = signed'({2'b00, v}) + (up ? 14'sd1 : -14'sd1);
    if (r < signed'({2'b00, lo})) r = signed'({2'b00, hi});
    if (r > signed'({2'b00, hi})) r = signed'({2'b00, lo});
    return r[11:0];
  endfunction

  function automatic logic [5:0] wrap_small(input logic [5:0] v, input logic up,
                                            input logic [5:0] lo, input logic [5:0] hi);
    logic signed [7:0] r;
    r = signed'({2'b00, v}) + (up ? 8'sd1 : -8'sd1);
    if (r < signed'({2'b00, lo})) r = signed'({2'b00, hi});
    if (r > signed'({2'b00, hi})) r = signed'({2'b00, lo});
    return r[5:0];
  endfunction

  function automatic logic [2:0] cursor_next(input logic [2:0] c);
    logic [2:0] n;
    case (c)
      3'd5:    n = 3'd0;
      3'd6:    n = 3'd1;
      3'd7:    n = 3'd2;
      default: n = c + 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] cursor_prev(input logic [2:0] c);
    logic [2:0] n;
    case (c)
      3'd0:    n = 3'd5;
      3'd6:    n = 3'd5;
      3'd7:    n = 3'd0;
      default: n = c - 3'd1;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/dtse_decode.sv
// Event decoder: turns one request into an edit command and an action.
module dtse_decode (
  input  logic [1:0]    operation,
  input  logic [1:0]    event_source,
  input  logic [1:0]    event_kind,
  input  logic [7:0]    button_number,
  input  logic [3:0]    key_length,
  input  logic [23:0]   key_bytes,
  output dtse_pkg::cmd_t cmd
);
  import dtse_pkg::*;

  logic [7:0] b0, b1, b2;
  logic       btn_a;

  assign b0    = key_bytes[7:0];
  assign b1    = key_bytes[15:8];
  assign b2    = key_bytes[23:16];
  assign btn_a = (button_number == BUTTON_A);

  always_comb begin
    cmd.op     = CMD_NONE;
    cmd.action = ACT_NONE;
    case (operation)
      OP_LOAD:    cmd.op = CMD_LOAD;
      OP_DEFAULT: cmd.op = CMD_DEFAULT;
      OP_EVENT: begin
        if (event_source == SRC_BUTTON && event_kind == KIND_SHORT) begin
          cmd.op = btn_a ? CMD_CUR_NEXT : CMD_STEP_DN;
        end else if (event_source == SRC_BUTTON && event_kind == KIND_LONG) begin
          if (btn_a) cmd.op = CMD_STEP_UP;
          else cmd.action = ACT_SAVE;
        end else if (event_source == SRC_KEYBOARD && event_kind == KIND_KEYPRESS) begin
          if (key_length == KEY_LEN_SEQ && b0 == KEY_ESC && b1 == KEY_BRACKET) begin
            case (b2)
              KEY_UP:    cmd.op = CMD_STEP_UP;
              KEY_DOWN:  cmd.op = CMD_STEP_DN;
              KEY_RIGHT: cmd.op = CMD_CUR_NEXT;
              KEY_LEFT:  cmd.op = CMD_CUR_PREV;
              default:   cmd.op = CMD_NONE;
            endcase
          end else if (key_length == KEY_LEN_ONE && b0 == KEY_CR) begin
            cmd.action = ACT_SAVE;
          end else if (key_length == KEY_LEN_ONE && b0 == KEY_ESC) begin
            cmd.action = ACT_CANCEL;
          end
        end
      end
      default: cmd.op = CMD_NONE;
    endcase
  end

endmodule

FILE: hdl/dtse_core.sv
// Edit state: date, time and cursor registers with step, wrap and day clamp.
module dtse_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  dtse_pkg::cmd_t cmd,
  input  dtse_pkg::dt_t  load,
  input  logic [11:0]    year_min,
  input  logic [11:0]    year_max,
  output dtse_pkg::dt_t  dt,
  output logic [2:0]     cursor
);
  import dtse_pkg::*;

  dt_t        dt_r, dt_nxt, stepped;
  logic [2:0] cursor_r, cursor_nxt;
  logic [4:0] dim_old, dim_new;
  logic       up;

  assign up      = (cmd.op == CMD_STEP_UP);
  assign dim_old = month_days(dt_r.year, dt_r.month);

  // Step the selected field.
  always_comb begin
    stepped = dt_r;
    case (cursor_r)
      CUR_YEAR:   stepped.year   = wrap_year(dt_r.year, up, year_min, year_max);
      CUR_MONTH:  stepped.month  = 4'(wrap_small({2'b00, dt_r.month}, up, 6'd1, 6'd12));
      CUR_DAY:    stepped.day    = 5'(wrap_small({1'b0, dt_r.day}, up, 6'd1, {1'b0, dim_old}));
      CUR_HOUR:   stepped.hour   = 5'(wrap_small({1'b0, dt_r.hour}, up, 6'd0, 6'd23));
      CUR_MINUTE: stepped.minute = wrap_small(dt_r.minute, up, 6'd0, 6'd59);
      CUR_SECOND: stepped.second = wrap_small(dt_r.second, up, 6'd0, 6'd59);
      default:    stepped = dt_r;
    endcase
  end

  assign dim_new = month_days(stepped.year, stepped.month);

  always_comb begin
    dt_nxt     = dt_r;
    cursor_nxt = cursor_r;
    case (cmd.op)
      CMD_LOAD: begin
        dt_nxt     = load;
        cursor_nxt = CUR_YEAR;
      end
      CMD_DEFAULT: begin
        dt_nxt     = '{year: YEAR_DEF, month: 4'd1, day: 5'd1,
                       hour: 5'd0, minute: 6'd0, second: 6'd0};
        cursor_nxt = CUR_YEAR;
      end
      CMD_STEP_UP, CMD_STEP_DN: begin
        dt_nxt = stepped;
        // clamp the day into the month after any step
        if (stepped.day > dim_new) dt_nxt.day = dim_new;
        else if (stepped.day == 5'd0) dt_nxt.day = 5'd1;
      end
      CMD_CUR_NEXT: cursor_nxt = cursor_next(cursor_r);
      CMD_CUR_PREV: cursor_nxt = cursor_prev(cursor_r);
      default: begin
        dt_nxt     = dt_r;
        cursor_nxt = cursor_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r     <= '{year: YEAR_DEF, month: 4'd1, day: 5'd1,
                    hour: 5'd0, minute: 6'd0, second: 6'd0};
      cursor_r <= CUR_YEAR;
    end else if (en) begin
      dt_r     <= dt_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  assign dt     = dt_r;
  assign cursor = cursor_r;

endmodule

FILE: hdl/date_time_set_editor.sv
// Top level of the date and time set editor.
//
// Date and time set editor. Every accepted request gives exactly one result:
// the date, time and cursor after the request, plus an action code (none,
// save request, cancel). A request goes first into an input register, where
// the decoded command and load values wait; once the result slot is free or
// is being emptied, the edit logic steps, wraps and clamps the selected field
// and writes the new state, which is itself the result register. One request
// is taken every cycle as long as results are taken; the state feedback
// through the step and day-clamp logic sets that one-per-cycle figure. While
// a result waits, the input register still takes one more request. The user
// must write the year bounds over the APB port (year_min at 0x0, year_max at
// 0x4) only while the block is idle; the block itself does not enforce this.
module date_time_set_editor (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_event_source,
  input  logic [1:0]  in_event_kind,
  input  logic [7:0]  in_button_number,
  input  logic [3:0]  in_key_length,
  input  logic [23:0] in_key_bytes,
  input  logic [11:0] in_load_year,
  input  logic [3:0]  in_load_month,
  input  logic [4:0]  in_load_day,
  input  logic [4:0]  in_load_hour,
  input  logic [5:0]  in_load_minute,
  input  logic [5:0]  in_load_second,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_cursor,
  output logic [1:0]  out_action,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dtse_pkg::*;

  cmd_t        cmd_in, cmd_r;
  dt_t         load_r, dt;
  logic        s1_v_r, s1_v_nxt;
  logic        out_v_r, out_v_nxt;
  action_t     action_r;
  logic        adv;
  logic        in_fire;
  logic        cfg_wr;
  logic [11:0] year_min_r, year_max_r;
  logic [2:0]  cursor;

  // Configuration registers: written on the access phase of an APB write.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_min_r <= YEAR_MIN_RST;
      year_max_r <= YEAR_MAX_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_YEAR_MIN) year_min_r <= pwdata[11:0];
      else year_max_r <= pwdata[11:0];
    end
  end

  always_comb begin
    prdata = {20'd0, (paddr[2] == REG_YEAR_MIN) ? year_min_r : year_max_r};
  end

  // Decode the incoming request before it is registered.
  dtse_decode u_decode (
    .operation     (in_operation),
    .event_source  (in_event_source),
    .event_kind    (in_event_kind),
    .button_number (in_button_number),
    .key_length    (in_key_length),
    .key_bytes     (in_key_bytes),
    .cmd           (cmd_in)
  );

  // Advance the held request into the state when the result slot is free
  // or is being emptied in this cycle.
  assign adv      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) s1_v_nxt = 1'b1;
    else if (adv) s1_v_nxt = 1'b0;
    out_v_nxt = out_v_r;
    if (adv) out_v_nxt = 1'b1;
    else if (out_ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Hold the decoded request and its load values; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= cmd_in;
      load_r <= '{year: in_load_year, month: in_load_month, day: in_load_day,
                  hour: in_load_hour, minute: in_load_minute, second: in_load_second};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) action_r <= cmd_r.action;
  end

  // Edit state doubles as the result register: it only changes on advance.
  dtse_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cmd      (cmd_r),
    .load     (load_r),
    .year_min (year_min_r),
    .year_max (year_max_r),
    .dt       (dt),
    .cursor   (cursor)
  );

  assign out_valid  = out_v_r;
  assign out_year   = dt.year;
  assign out_month  = dt.month;
  assign out_day    = dt.day;
  assign out_hour   = dt.hour;
  assign out_minute = dt.minute;
  assign out_second = dt.second;
  assign out_cursor = cursor;
  assign out_action = action_r;

endmodule

FILE: hdl/dtse_checker.sv
// Port-level checker for the date and time set editor, with its bind.
module dtse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_second,
  input logic [2:0]  out_cursor,
  input logic [1:0]  out_action
);
  import dtse_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_day) && $stable(out_hour) && $stable(out_minute)
      && $stable(out_second) && $stable(out_cursor) && $stable(out_action))
    else $error("result changed while stalled");

  // Requests stall only when a result is waiting.
  a_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with result slot free");

  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor <= CUR_SECOND)
    else $error("cursor out of range");

  a_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_action == ACT_NONE) || (out_action == ACT_SAVE)
      || (out_action == ACT_CANCEL))
    else $error("bad action code");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind date_time_set_editor dtse_checker u_dtse_checker (.*);
